@@ src/csvt_pkg.sv @@
// Package for the CSV field tokenizer: character codes, result kinds,
// tokenizer state and result types, and the saturation helpers.
// No dependencies.
`default_nettype none

package csvt_pkg;

  localparam int MAX_COLUMNS = 256;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int WID_W       = $clog2(MAX_COLUMNS + 1);
  localparam int ROW_W       = 32;

  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_COMMA   = 8'h2C;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = '1;

  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_ROW_END   = 2'd2
  } kind_t;

  typedef struct packed {
    logic             in_quoted;
    logic             quote_pending;
    logic             field_nonempty;
    logic [COL_W-1:0] column_index;
    logic [ROW_W-1:0] row_index;
    logic [WID_W-1:0] widest_seen;
  } state_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [7:0] column;
    logic [31:0] row;
    logic [8:0] widest_columns;
    logic       last_of_run;
  } result_t;

  function automatic logic [7:0] sat_column(logic [COL_W-1:0] c);
    if (32'(c) > 32'd255) begin
      return 8'hFF;
    end
    return 8'(c);
  endfunction

  function automatic logic [8:0] sat_widest(logic [WID_W-1:0] w);
    if (32'(w) > 32'd511) begin
      return 9'h1FF;
    end
    return 9'(w);
  endfunction

endpackage

`default_nettype wire

@@ src/csvt_if.sv @@
// Stream interfaces of the CSV field tokenizer: byte input and result output.
// Depends on nothing but the handshake convention valid/ready.
`default_nettype none

interface csvt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

interface csvt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [7:0]  column;
  logic [31:0] row;
  logic [8:0]  widest_columns;
  logic        last_of_run;

  modport source (output valid, output kind, output data_byte, output column,
                  output row, output widest_columns, output last_of_run, input ready);
  modport sink (input valid, input kind, input data_byte, input column,
                input row, input widest_columns, input last_of_run, output ready);
endinterface

`default_nettype wire

@@ src/csvt_step.sv @@
// Per-byte tokenizer rule: next state and up to two results for one byte.
// Depends on csvt_pkg.
`default_nettype none

module csvt_step (
  input  var csvt_pkg::state_t  state_i,
  input  var logic [7:0]        delimiter,
  input  var logic [7:0]        text_byte,
  input  var logic              final_byte,
  output csvt_pkg::state_t      state_o,
  output csvt_pkg::result_t     res0,
  output csvt_pkg::result_t     res1,
  output logic [1:0]            res_cnt
);

  csvt_pkg::state_t  s;
  csvt_pkg::result_t r_part;
  csvt_pkg::result_t r_fin;
  logic              have_part;
  logic              have_fin;
  logic              done;

  function automatic csvt_pkg::result_t mk(csvt_pkg::kind_t k, logic [7:0] d,
                                            csvt_pkg::state_t st);
    csvt_pkg::result_t r;
    r.kind           = k;
    r.data_byte      = d;
    r.column         = csvt_pkg::sat_column(st.column_index);
    r.row            = st.row_index;
    r.widest_columns = csvt_pkg::sat_widest(st.widest_seen);
    r.last_of_run    = 1'b0;
    return r;
  endfunction

  function automatic logic [csvt_pkg::WID_W-1:0] widen(csvt_pkg::state_t st);
    logic [csvt_pkg::WID_W-1:0] fields;
    fields = csvt_pkg::WID_W'(st.column_index) + csvt_pkg::WID_W'(1);
    return (fields > st.widest_seen) ? fields : st.widest_seen;
  endfunction

  always_comb begin
    s         = state_i;
    r_part    = '0;
    r_fin     = '0;
    have_part = 1'b0;
    have_fin  = 1'b0;
    done      = 1'b0;

    // resolve a held quote
    if (s.quote_pending) begin
      s.quote_pending = 1'b0;
      if (text_byte == csvt_pkg::CH_QUOTE) begin
        s.field_nonempty = 1'b1;
        r_part    = mk(csvt_pkg::KIND_DATA, text_byte, s);
        have_part = 1'b1;
        done      = 1'b1;
      end else begin
        s.in_quoted = 1'b0;
      end
    end

    if (!done) begin
      if (s.in_quoted) begin
        if (text_byte == csvt_pkg::CH_QUOTE) begin
          s.quote_pending = 1'b1;
        end else begin
          s.field_nonempty = 1'b1;
          r_part    = mk(csvt_pkg::KIND_DATA, text_byte, s);
          have_part = 1'b1;
        end
      end else if (text_byte == csvt_pkg::CH_QUOTE) begin
        s.in_quoted = 1'b1;
      end else if (text_byte == delimiter) begin
        r_part    = mk(csvt_pkg::KIND_FIELD_END, 8'h00, s);
        have_part = 1'b1;
        if (s.column_index != csvt_pkg::COL_LAST) begin
          s.column_index = s.column_index + csvt_pkg::COL_W'(1);
        end
        s.field_nonempty = 1'b0;
      end else if (text_byte == csvt_pkg::CH_NEWLINE) begin
        s.widest_seen = widen(s);
        r_part    = mk(csvt_pkg::KIND_ROW_END, 8'h00, s);
        have_part = 1'b1;
        s.column_index = '0;
        if (s.row_index != csvt_pkg::ROW_LAST) begin
          s.row_index = s.row_index + 32'd1;
        end
        s.field_nonempty = 1'b0;
      end else if (text_byte != csvt_pkg::CH_CR) begin
        s.field_nonempty = 1'b1;
        r_part    = mk(csvt_pkg::KIND_DATA, text_byte, s);
        have_part = 1'b1;
      end
    end

    // flush the open row on the last byte, then start a new document
    if (final_byte) begin
      if (s.field_nonempty || (s.column_index != '0)) begin
        s.widest_seen = widen(s);
        r_fin    = mk(csvt_pkg::KIND_ROW_END, 8'h00, s);
        have_fin = 1'b1;
      end
      s = '0;
    end

    state_o = s;
    res0    = have_part ? r_part : r_fin;
    res0.last_of_run = !(have_part && have_fin);
    res1    = r_fin;
    res1.last_of_run = 1'b1;
    res_cnt = {1'b0, have_part} + {1'b0, have_fin};
  end

endmodule

`default_nettype wire

@@ src/csv_field_tokenizer.sv @@
// Results are registered: an accepted byte's results are driven from the result buffer.
// Throughput: one byte per cycle while each byte gives at most one result;
// a stalled output or a byte that gives two results holds the input (one result port).
// Reset (synchronous, rst_n low): tokenizer state cleared, delimiter set to comma,
// result buffer emptied.
`default_nettype none

module csv_field_tokenizer (
  input  var logic   clk,
  input  var logic   rst_n,
  csvt_in_if.sink    in_ch,
  csvt_out_if.source out_ch,
  input  var logic   cfg_we,
  input  var logic [7:0] cfg_wdata
);

  csvt_pkg::state_t  state_r, state_nxt;
  csvt_pkg::result_t slot0_r, slot1_r;
  csvt_pkg::result_t res0, res1;
  logic [1:0]        cnt_r, res_cnt;
  logic [7:0]        delim_r;
  logic              in_acc;
  logic              out_pop;

  csvt_step u_step (
    .state_i    (state_r),
    .delimiter  (delim_r),
    .text_byte  (in_ch.text_byte),
    .final_byte (in_ch.final_byte),
    .state_o    (state_nxt),
    .res0       (res0),
    .res1       (res1),
    .res_cnt    (res_cnt)
  );

  assign out_pop     = (cnt_r != 2'd0) && out_ch.ready;
  assign in_ch.ready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
      cnt_r   <= 2'd0;
      delim_r <= csvt_pkg::CH_COMMA;
    end else begin
      if (cfg_we) begin
        delim_r <= cfg_wdata;
      end
      if (in_acc) begin
        state_r <= state_nxt;
        cnt_r   <= res_cnt;
      end else if (out_pop) begin
        cnt_r   <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      slot0_r <= res0;
      slot1_r <= res1;
    end else if (out_pop) begin
      slot0_r <= slot1_r;
    end
  end

  assign out_ch.valid          = (cnt_r != 2'd0);
  assign out_ch.kind           = slot0_r.kind;
  assign out_ch.data_byte      = slot0_r.data_byte;
  assign out_ch.column         = slot0_r.column;
  assign out_ch.row            = slot0_r.row;
  assign out_ch.widest_columns = slot0_r.widest_columns;
  assign out_ch.last_of_run    = slot0_r.last_of_run;

endmodule

`default_nettype wire

@@ src/csvt_checker.sv @@
// Port-level checks for the CSV field tokenizer, bound to the top level.
// Depends on csvt_pkg and csv_field_tokenizer.
`default_nettype none

module csvt_checker (
  input var logic        clk,
  input var logic        rst_n,
  input var logic        out_valid,
  input var logic        out_ready,
  input var logic [1:0]  kind,
  input var logic [7:0]  data_byte,
  input var logic [7:0]  column,
  input var logic [31:0] row,
  input var logic        last_of_run
);

  a_no_beat_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (kind == csvt_pkg::KIND_DATA || kind == csvt_pkg::KIND_FIELD_END ||
                   kind == csvt_pkg::KIND_ROW_END))
    else $error("illegal result kind");

  a_marker_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && kind != csvt_pkg::KIND_DATA) |-> (data_byte == 8'h00))
    else $error("field or row end carries data");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(kind) && $stable(data_byte) &&
                                  $stable(column) && $stable(row) && $stable(last_of_run)))
    else $error("stalled result beat changed");

endmodule

bind csv_field_tokenizer csvt_checker u_csvt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .kind        (out_ch.kind),
  .data_byte   (out_ch.data_byte),
  .column      (out_ch.column),
  .row         (out_ch.row),
  .last_of_run (out_ch.last_of_run)
);

`default_nettype wire
